[sv/imeu_pkg.sv]
// Package for the micro-op execute unit: opcodes, condition codes,
// result actions and the structs passed between pipeline stages. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imeu_pkg;

    // Micro-op kinds, numbered as the front end sends them
    typedef enum logic [4:0] {
        OP_GET_REG    = 5'd0,
        OP_SET_REG    = 5'd1,
        OP_GET_EXT    = 5'd2,
        OP_SET_EXT    = 5'd3,
        OP_GET_STATUS = 5'd4,
        OP_SET_STATUS = 5'd5,
        OP_SET_NZCV   = 5'd6,
        OP_ADD        = 5'd7,
        OP_SUB        = 5'd8,
        OP_LSL        = 5'd9,
        OP_LSR        = 5'd10,
        OP_MEM_RD     = 5'd11,
        OP_MEM_WR     = 5'd12,
        OP_BX         = 5'd13,
        OP_CSEL       = 5'd14,
        OP_SVC        = 5'd15,
        OP_IDENT      = 5'd16,
        OP_VOID       = 5'd17,
        OP_MUL        = 5'd18,
        OP_AND        = 5'd19,
        OP_OR         = 5'd20,
        OP_XOR        = 5'd21,
        OP_ASR        = 5'd22,
        OP_GET_C      = 5'd23,
        OP_GET_NZCV   = 5'd24,
        OP_OTHER      = 5'd25
    } op_t;

    // Condition codes; anything above LE is always true
    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13
    } cond_t;

    typedef enum logic [1:0] {
        ACT_MEM_RD    = 2'd0,
        ACT_MEM_WR    = 2'd1,
        ACT_SVC       = 2'd2,
        ACT_BLOCK_END = 2'd3
    } action_t;

    localparam logic [31:0] STATUS_LOW_MASK = 32'h0FFF_FFFF;
    localparam int          STATUS_T_BIT    = 5;
    localparam logic [9:0]  EXEC_MAX        = 10'd1023;

    // One micro-op as held in the execute stage
    typedef struct packed {
        logic [4:0]       opcode;
        logic [8:0]       dest_slot;
        logic [1:0]       arg_count;
        logic [2:0]       is_imm;
        logic [2:0][63:0] val;
        logic [31:0]      mem_read_data;
        logic             last_in_block;
        logic [31:0]      block_end_pc;
    } item_t;

    // One result beat
    typedef struct packed {
        action_t     action;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic [31:0] svc_number;
        logic [31:0] next_pc;
        logic [10:0] tick_count;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

[sv/imeu_ifs.sv]
// Valid/ready channel interfaces for the micro-op execute unit.
// Input carries one micro-op per beat, output one result per beat. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface imeu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  opcode;
    logic [8:0]  dest_slot;
    logic [1:0]  arg_count;
    logic        arg0_is_imm;
    logic [63:0] arg0_value;
    logic        arg1_is_imm;
    logic [63:0] arg1_value;
    logic        arg2_is_imm;
    logic [63:0] arg2_value;
    logic [31:0] mem_read_data;
    logic        last_in_block;
    logic [31:0] block_end_pc;

    modport source (output valid, opcode, dest_slot, arg_count, arg0_is_imm, arg0_value,
                    arg1_is_imm, arg1_value, arg2_is_imm, arg2_value, mem_read_data,
                    last_in_block, block_end_pc, input ready);
    modport sink (input valid, opcode, dest_slot, arg_count, arg0_is_imm, arg0_value,
                  arg1_is_imm, arg1_value, arg2_is_imm, arg2_value, mem_read_data,
                  last_in_block, block_end_pc, output ready);
endinterface

interface imeu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [31:0] svc_number;
    logic [31:0] next_pc;
    logic [10:0] tick_count;
    logic        last;

    modport source (output valid, action, mem_address, mem_write_data, svc_number,
                    next_pc, tick_count, last, input ready);
    modport sink (input valid, action, mem_address, mem_write_data, svc_number,
                  next_pc, tick_count, last, output ready);
endinterface
`default_nettype wire

[sv/ir_micro_op_execute_unit.sv]
// Top level of the micro-op execute unit: slot store, flag store, register files,
// execute stage and result queue. Depends on imeu_pkg, imeu_ifs and imeu_ram.
`timescale 1ns / 1ps
`default_nettype none
// Takes one micro-op per cycle whenever the result queue has room for two beats.
// The input beat issues the reads of the slot, flag and extension-register RAMs
// (registered read data); the execute stage then computes and writes back, with a
// one-entry bypass per RAM covering the write made in the same cycle as the read.
// Memory reads, memory writes and supervisor calls give one result beat, the end
// of a block another; both go into a four-entry result queue, so a stalled output
// stops the input once the queue holds more than two beats. Items after a branch up
// to the last item of the block are consumed without effect. Slot contents are
// undefined until written; extension registers read as zero until written.
module ir_micro_op_execute_unit #(
    parameter int SLOT_COUNT    = 512,
    parameter int EXT_REG_COUNT = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    imeu_in_if.sink     in_ch,
    imeu_out_if.source  out_ch
);
    import imeu_pkg::*;

    localparam int AW     = $clog2(SLOT_COUNT);
    localparam int EW     = $clog2(EXT_REG_COUNT);
    localparam int QDEPTH = 4;
    localparam int QW     = $clog2(QDEPTH);

    // ---------------- input stage / RAM read issue ----------------
    logic        in_fire;
    logic        s1_fire;
    logic        s1_valid_reg;
    item_t       s1_reg;
    logic [63:0] raw0_in;
    logic [2:0][63:0] in_val;

    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign raw0_in     = (in_ch.arg_count != 2'd0) ? in_ch.arg0_value : 64'd0;
    assign in_val      = {in_ch.arg2_value, in_ch.arg1_value, in_ch.arg0_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg.opcode        <= in_ch.opcode;
            s1_reg.dest_slot     <= in_ch.dest_slot;
            s1_reg.arg_count     <= in_ch.arg_count;
            s1_reg.is_imm        <= {in_ch.arg2_is_imm, in_ch.arg1_is_imm, in_ch.arg0_is_imm};
            s1_reg.val           <= in_val;
            s1_reg.mem_read_data <= in_ch.mem_read_data;
            s1_reg.last_in_block <= in_ch.last_in_block;
            s1_reg.block_end_pc  <= in_ch.block_end_pc;
        end
    end

    // ---------------- memories ----------------
    logic          slot_we;
    logic [AW-1:0] slot_waddr;
    logic [63:0]   slot_wdata;
    logic [63:0]   slot_rd [3];
    logic          flag_we;
    logic [3:0]    flag_wdata;
    logic [3:0]    flag_rd;
    logic          ext_we;
    logic [EW-1:0] ext_waddr;
    logic [31:0]   ext_wdata;
    logic [31:0]   ext_rd;

    // One copy of the slot store per operand, all written alike
    for (genvar k = 0; k < 3; k++)
    begin : g_slot
        imeu_ram #(.DEPTH(SLOT_COUNT), .WIDTH(64)) u_slot (
            .clk   (clk),
            .we    (slot_we),
            .waddr (slot_waddr),
            .wdata (slot_wdata),
            .re    (in_fire),
            .raddr (AW'(in_val[k])),
            .rdata (slot_rd[k])
        );
    end

    imeu_ram #(.DEPTH(SLOT_COUNT), .WIDTH(4)) u_flag (
        .clk   (clk),
        .we    (flag_we),
        .waddr (slot_waddr),
        .wdata (flag_wdata),
        .re    (in_fire),
        .raddr (AW'(raw0_in)),
        .rdata (flag_rd)
    );

    imeu_ram #(.DEPTH(EXT_REG_COUNT), .WIDTH(32)) u_ext (
        .clk   (clk),
        .we    (ext_we),
        .waddr (ext_waddr),
        .wdata (ext_wdata),
        .re    (in_fire),
        .raddr (EW'(raw0_in)),
        .rdata (ext_rd)
    );

    // ---------------- architectural state ----------------
    logic [31:0]   core_reg [16];
    logic [31:0]   status_reg;
    logic [31:0]   status_next;
    logic [9:0]    exec_reg;
    logic          skip_reg;
    logic [EXT_REG_COUNT-1:0] ext_vld_reg;

    // bypass of the write made at the edge that issued the current read
    logic          fwd_vld_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [63:0]   fwd_data_reg;
    logic          ffwd_vld_reg;
    logic [AW-1:0] ffwd_addr_reg;
    logic [3:0]    ffwd_data_reg;
    logic          efwd_vld_reg;
    logic [EW-1:0] efwd_addr_reg;
    logic [31:0]   efwd_data_reg;

    // ---------------- execute stage ----------------
    logic [63:0]   opnd [3];
    logic [63:0]   raw0;
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   sum;
    logic [31:0]   dif;
    logic [31:0]   mul;
    logic [4:0]    shamt;
    logic [3:0]    flags;
    logic          cond_ok;
    logic          n_f, z_f, c_f, v_f;
    logic          dst_rng;
    logic          raw0_slot_rng;
    logic          core_we;
    logic          blk_end;
    logic          branched;
    logic [31:0]   end_pc;
    logic [9:0]    exec_inc;
    logic          act;
    logic [31:0]   ext_val;
    logic [3:0]    flag_val;
    logic          skip_item;
    result_t       r0;
    result_t       r1;
    logic [1:0]    n_res;
    logic [QW:0]   q_cnt_reg;

    assign s1_fire = s1_valid_reg && (q_cnt_reg <= (QW+1)'(QDEPTH - 2));

    always_comb
    begin
        // operand fetch with bypass
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) >= s1_reg.arg_count)
            begin
                opnd[k] = 64'd0;
            end
            else if (s1_reg.is_imm[k])
            begin
                opnd[k] = s1_reg.val[k];
            end
            else if (s1_reg.val[k] < 64'(SLOT_COUNT))
            begin
                opnd[k] = (fwd_vld_reg && fwd_addr_reg == AW'(s1_reg.val[k]))
                          ? fwd_data_reg : slot_rd[k];
            end
            else
            begin
                opnd[k] = 64'd0;
            end
        end
    end

    assign raw0  = (s1_reg.arg_count != 2'd0) ? s1_reg.val[0] : 64'd0;
    assign a     = opnd[0][31:0];
    assign b     = opnd[1][31:0];
    assign sum   = a + b;
    assign dif   = a - b;
    assign mul   = a * b;
    assign shamt = opnd[1][4:0];
    assign dst_rng       = 32'(s1_reg.dest_slot) < 32'(SLOT_COUNT);
    assign raw0_slot_rng = raw0 < 64'(SLOT_COUNT);
    assign skip_item     = skip_reg;
    assign act           = s1_fire && !skip_item;

    assign n_f = status_reg[31];
    assign z_f = status_reg[30];
    assign c_f = status_reg[29];
    assign v_f = status_reg[28];

    // extension register and flag entry reads
    always_comb
    begin
        if (raw0 < 64'(EXT_REG_COUNT) && ext_vld_reg[EW'(raw0)])
        begin
            ext_val = (efwd_vld_reg && efwd_addr_reg == EW'(raw0)) ? efwd_data_reg : ext_rd;
        end
        else
        begin
            ext_val = 32'd0;
        end
        if (raw0_slot_rng)
        begin
            flag_val = (ffwd_vld_reg && ffwd_addr_reg == AW'(raw0)) ? ffwd_data_reg : flag_rd;
        end
        else
        begin
            flag_val = 4'd0;
        end
    end

    // condition evaluation
    always_comb
    begin
        cond_ok = 1'b1;
        if (raw0 <= 64'(COND_LE))
        begin
            case (cond_t'(raw0[3:0]))
                COND_EQ: cond_ok = z_f;
                COND_NE: cond_ok = !z_f;
                COND_CS: cond_ok = c_f;
                COND_CC: cond_ok = !c_f;
                COND_MI: cond_ok = n_f;
                COND_PL: cond_ok = !n_f;
                COND_VS: cond_ok = v_f;
                COND_VC: cond_ok = !v_f;
                COND_HI: cond_ok = c_f && !z_f;
                COND_LS: cond_ok = !c_f || z_f;
                COND_GE: cond_ok = n_f == v_f;
                COND_LT: cond_ok = n_f != v_f;
                COND_GT: cond_ok = !z_f && (n_f == v_f);
                COND_LE: cond_ok = z_f || (n_f != v_f);
                default: cond_ok = 1'b1;
            endcase
        end
    end

    // add/subtract flags
    always_comb
    begin
        if (s1_reg.opcode == OP_ADD)
        begin
            flags = {sum[31], sum == 32'd0, sum < a, (~(a ^ b) & (a ^ sum)) >> 31 != 32'd0};
        end
        else
        begin
            flags = {dif[31], dif == 32'd0, a >= b, ((a ^ b) & (a ^ dif)) >> 31 != 32'd0};
        end
    end

    // result value, side effects
    always_comb
    begin
        slot_we     = 1'b0;
        slot_wdata  = 64'd0;
        flag_we     = 1'b0;
        core_we     = 1'b0;
        ext_we      = 1'b0;
        branched    = 1'b0;
        status_next = status_reg;
        case (s1_reg.opcode)
            OP_GET_REG:
            begin
                slot_we    = 1'b1;
                slot_wdata = (raw0 < 64'd16) ? 64'(core_reg[raw0[3:0]]) : 64'd0;
            end
            OP_SET_REG:    core_we = raw0 < 64'd16;
            OP_GET_EXT:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(ext_val);
            end
            OP_SET_EXT:    ext_we = raw0 < 64'(EXT_REG_COUNT);
            OP_GET_STATUS:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(status_reg);
            end
            OP_SET_STATUS: status_next = a;
            OP_SET_NZCV:   status_next = (status_reg & STATUS_LOW_MASK) | {a[3:0], 28'd0};
            OP_ADD, OP_SUB:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'((s1_reg.opcode == OP_ADD) ? sum : dif);
                flag_we    = 1'b1;
                if (s1_reg.arg_count == 2'd3 && s1_reg.is_imm[2] && s1_reg.val[2] != 64'd0)
                begin
                    status_next = (status_reg & STATUS_LOW_MASK) | {flags, 28'd0};
                end
            end
            OP_LSL:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(a << shamt);
            end
            OP_LSR:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(a >> shamt);
            end
            OP_MEM_RD:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(s1_reg.mem_read_data);
            end
            OP_BX:
            begin
                branched = 1'b1;
                status_next[STATUS_T_BIT] = a[0];
            end
            OP_CSEL:
            begin
                slot_we    = 1'b1;
                slot_wdata = cond_ok ? opnd[1] : opnd[2];
            end
            OP_IDENT:
            begin
                slot_we    = 1'b1;
                slot_wdata = opnd[0];
            end
            OP_MUL:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(mul);
            end
            OP_AND:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(a & b);
            end
            OP_OR:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(a | b);
            end
            OP_XOR:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(a ^ b);
            end
            OP_ASR:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(32'($signed(a) >>> shamt));
            end
            OP_GET_C:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(status_reg[29]);
            end
            OP_GET_NZCV:
            begin
                slot_we    = 1'b1;
                slot_wdata = 64'(flag_val);
            end
            default: ;
        endcase
        slot_we = slot_we && act && dst_rng;
        flag_we = flag_we && act && dst_rng;
        ext_we  = ext_we && act;
    end

    assign slot_waddr = AW'(s1_reg.dest_slot);
    assign flag_wdata = flags;
    assign ext_waddr  = EW'(raw0);
    assign ext_wdata  = b;

    // block end and result beats
    assign blk_end  = branched || s1_reg.last_in_block;
    assign end_pc   = branched ? (a & ~32'd1) : s1_reg.block_end_pc;
    assign exec_inc = (exec_reg < EXEC_MAX) ? exec_reg + 10'd1 : exec_reg;

    always_comb
    begin
        result_t side;
        result_t fin;
        logic    has_side;
        side     = '0;
        fin      = '0;
        has_side = 1'b0;
        case (s1_reg.opcode)
            OP_MEM_RD:
            begin
                has_side         = 1'b1;
                side.action      = ACT_MEM_RD;
                side.mem_address = a;
            end
            OP_MEM_WR:
            begin
                has_side            = 1'b1;
                side.action         = ACT_MEM_WR;
                side.mem_address    = a;
                side.mem_write_data = b;
            end
            OP_SVC:
            begin
                has_side        = 1'b1;
                side.action     = ACT_SVC;
                side.svc_number = raw0[31:0];
            end
            default: ;
        endcase
        fin.action     = ACT_BLOCK_END;
        fin.next_pc    = end_pc;
        fin.tick_count = {exec_inc, 1'b0};
        fin.last       = 1'b1;
        side.last      = !blk_end;
        r0    = has_side ? side : fin;
        r1    = fin;
        n_res = 2'(has_side) + 2'(blk_end);
        if (skip_item)
        begin
            n_res = 2'd0;
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                core_reg[i] <= 32'd0;
            end
            status_reg    <= 32'd0;
            exec_reg      <= 10'd0;
            skip_reg      <= 1'b0;
            ext_vld_reg   <= '0;
            fwd_vld_reg   <= 1'b0;
            ffwd_vld_reg  <= 1'b0;
            efwd_vld_reg  <= 1'b0;
        end
        else if (s1_fire)
        begin
            fwd_vld_reg  <= slot_we;
            ffwd_vld_reg <= flag_we;
            efwd_vld_reg <= ext_we;
            if (skip_item)
            begin
                if (s1_reg.last_in_block)
                begin
                    skip_reg <= 1'b0;
                end
            end
            else
            begin
                status_reg <= status_next;
                if (core_we)
                begin
                    core_reg[raw0[3:0]] <= b;
                end
                if (ext_we)
                begin
                    ext_vld_reg[EW'(raw0)] <= 1'b1;
                end
                if (blk_end)
                begin
                    core_reg[15] <= end_pc;
                    exec_reg     <= 10'd0;
                    skip_reg     <= branched && !s1_reg.last_in_block;
                end
                else
                begin
                    exec_reg <= exec_inc;
                end
            end
        end
    end

    // bypass payloads
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            fwd_addr_reg  <= slot_waddr;
            fwd_data_reg  <= slot_wdata;
            ffwd_addr_reg <= slot_waddr;
            ffwd_data_reg <= flag_wdata;
            efwd_addr_reg <= ext_waddr;
            efwd_data_reg <= ext_wdata;
        end
    end

    // ---------------- result queue ----------------
    result_t     q_reg [QDEPTH];
    logic [QW-1:0] q_head_reg;
    logic [QW-1:0] q_tail_reg;
    logic        out_fire;
    logic [1:0]  push_n;

    assign out_fire = out_ch.valid && out_ch.ready;
    assign push_n   = s1_fire ? n_res : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg <= '0;
            q_tail_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            q_tail_reg <= q_tail_reg + QW'(push_n);
            q_head_reg <= q_head_reg + QW'(out_fire);
            q_cnt_reg  <= q_cnt_reg + (QW+1)'(push_n) - (QW+1)'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_reg[q_tail_reg] <= r0;
        end
        if (push_n == 2'd2)
        begin
            q_reg[q_tail_reg + QW'(1)] <= r1;
        end
    end

    assign out_ch.valid          = q_cnt_reg != '0;
    assign out_ch.action         = q_reg[q_head_reg].action;
    assign out_ch.mem_address    = q_reg[q_head_reg].mem_address;
    assign out_ch.mem_write_data = q_reg[q_head_reg].mem_write_data;
    assign out_ch.svc_number     = q_reg[q_head_reg].svc_number;
    assign out_ch.next_pc        = q_reg[q_head_reg].next_pc;
    assign out_ch.tick_count     = q_reg[q_head_reg].tick_count;
    assign out_ch.last           = q_reg[q_head_reg].last;

    // ---------------- checks ----------------
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= (QW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_fire_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |-> q_cnt_reg <= (QW+1)'(QDEPTH - 2))
        else $error("execute stage retired without queue room");

    a_skip_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && skip_reg && s1_reg.last_in_block) |=> !skip_reg)
        else $error("skipping not cleared by last item");

    a_end_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.action == ACT_BLOCK_END) |-> out_ch.tick_count != 11'd0)
        else $error("block end with zero ticks");

    a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && skip_reg) |=> q_cnt_reg <= $past(q_cnt_reg))
        else $error("skipped item produced a result");
endmodule
`default_nettype wire

[sv/imeu_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module imeu_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire
